FILE: design/vdec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdec_pkg
// Shared types and constants for the vector distance block.
// ----------------------------------------------------------------------------
package vdec_pkg;

    localparam int MAX_LEN = 4096;
    localparam int CNT_W   = 13;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_NRM = 2'd1;
    localparam logic [1:0] STATUS_LEN_OVF  = 2'd2;

    localparam logic MODE_EUCLID = 1'b0;
    localparam logic MODE_COSINE = 1'b1;

    typedef struct packed {
        logic signed [15:0] elem_a;
        logic signed [15:0] elem_b;
        logic               last_elem;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] dist_value;
        logic [1:0]         status;
    } out_word_t;

    typedef struct packed {
        logic               mode;
        logic [CNT_W-1:0]   count;
        logic [45:0]        sum_sq_diff;
        logic [43:0]        sum_aa;
        logic [43:0]        sum_bb;
        logic signed [44:0] sum_ab;
        logic               overflow;
    } job_t;

    typedef struct packed {
        logic full;
        logic one_left;
    } qstat_t;

endpackage

FILE: design/vector_distance_euclid_cosine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_distance_euclid_cosine
// Streaming Euclidean / shifted cosine distance of two vectors.
// Throughput: one element pair per cycle while the job queue has room; the back
// works on one vector at a time: load, multiply, square root, divide and result
// for cosine, the same without the multiply for Euclidean, load and result for
// zero norm; a finished word waits in the back until the previous one is popped.
// Reset: rst_n clears counts, sums, queues and selects Euclidean mode.
// ----------------------------------------------------------------------------
module vector_distance_euclid_cosine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  logic                push,
    output logic                full,
    input  vdec_pkg::in_word_t  in_word,
    output logic                empty,
    input  logic                pop,
    output vdec_pkg::out_word_t out_word
);
    import vdec_pkg::*;

    logic   job_push, job_pop, job_valid;
    job_t   job_in, job_out;
    qstat_t qstat;

    vdec_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .push     (push),
        .full     (full),
        .in_word  (in_word),
        .qstat    (qstat),
        .job_push (job_push),
        .job_word (job_in)
    );

    vdec_jobq u_jobq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (job_push),
        .wr_word  (job_in),
        .rd       (job_pop),
        .nonempty (job_valid),
        .rd_word  (job_out),
        .qstat    (qstat)
    );

    vdec_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_word  (job_out),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

endmodule

FILE: design/vdec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdec_front
// Accepts element pairs, counts them and accumulates the four sums.
// ----------------------------------------------------------------------------
module vdec_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               push,
    output logic               full,
    input  vdec_pkg::in_word_t in_word,
    input  vdec_pkg::qstat_t   qstat,
    output logic               job_push,
    output vdec_pkg::job_t     job_word
);
    import vdec_pkg::*;

    logic             mode_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             s1_valid_reg, s1_last_reg, s1_skip_reg, s1_ovf_reg;
    logic signed [15:0] s1_a_reg, s1_b_reg;
    logic [CNT_W-1:0] s1_cnt_reg;
    logic [45:0]      ssd_reg, ssd_next;
    logic [43:0]      aa_reg, aa_next, bb_reg, bb_next;
    logic signed [44:0] ab_reg, ab_next;

    logic accept, skip;
    logic signed [16:0] d;
    logic signed [33:0] pdd;
    logic signed [31:0] paa, pbb, pab;

    assign full   = qstat.full || (qstat.one_left && s1_valid_reg && s1_last_reg);
    assign accept = push && !full;
    assign skip   = (cnt_reg >= CNT_W'(MAX_LEN));

    always_comb
    begin
        ovf_next = ovf_reg | skip;
        cnt_next = skip ? cnt_reg : cnt_reg + 1'b1;
    end

    always_comb
    begin
        d   = {s1_a_reg[15], s1_a_reg} - {s1_b_reg[15], s1_b_reg};
        pdd = d * d;
        paa = s1_a_reg * s1_a_reg;
        pbb = s1_b_reg * s1_b_reg;
        pab = s1_a_reg * s1_b_reg;
        ssd_next = ssd_reg;
        aa_next  = aa_reg;
        bb_next  = bb_reg;
        ab_next  = ab_reg;
        if (s1_valid_reg && !s1_skip_reg)
        begin
            ssd_next = ssd_reg + {12'd0, pdd};
            aa_next  = aa_reg + {12'd0, paa};
            bb_next  = bb_reg + {12'd0, pbb};
            ab_next  = ab_reg + {{13{pab[31]}}, pab};
        end
    end

    assign job_push = s1_valid_reg && s1_last_reg;
    always_comb
    begin
        job_word.mode        = mode_reg;
        job_word.count       = s1_cnt_reg;
        job_word.sum_sq_diff = ssd_next;
        job_word.sum_aa      = aa_next;
        job_word.sum_bb      = bb_next;
        job_word.sum_ab      = ab_next;
        job_word.overflow    = s1_ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_EUCLID;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            ssd_reg      <= '0;
            aa_reg       <= '0;
            bb_reg       <= '0;
            ab_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_last_reg <= in_word.last_elem;
                if (in_word.last_elem)
                begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_next;
                    ovf_reg <= ovf_next;
                end
            end
            if (job_push)
            begin
                ssd_reg <= '0;
                aa_reg  <= '0;
                bb_reg  <= '0;
                ab_reg  <= '0;
            end
            else
            begin
                ssd_reg <= ssd_next;
                aa_reg  <= aa_next;
                bb_reg  <= bb_next;
                ab_reg  <= ab_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_a_reg    <= in_word.elem_a;
            s1_b_reg    <= in_word.elem_b;
            s1_skip_reg <= skip;
            s1_cnt_reg  <= cnt_next;
            s1_ovf_reg  <= ovf_next;
        end
    end

endmodule

FILE: design/vdec_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdec_jobq
// Two-entry queue of finished accumulations between front and back.
// ----------------------------------------------------------------------------
module vdec_jobq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  vdec_pkg::job_t   wr_word,
    input  logic             rd,
    output logic             nonempty,
    output vdec_pkg::job_t   rd_word,
    output vdec_pkg::qstat_t qstat
);
    import vdec_pkg::*;

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign nonempty       = (cnt_reg != 2'd0);
    assign rd_word        = mem_reg[rp_reg];
    assign qstat.full     = (cnt_reg == 2'd2);
    assign qstat.one_left = (cnt_reg == 2'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_word;
    end

endmodule

FILE: design/vdec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdec_back
// Sequencer: shift-add multiply, bit-pair square root, restoring divide,
// saturation and the result register.
// ----------------------------------------------------------------------------
module vdec_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  vdec_pkg::job_t      job_word,
    output logic                job_pop,
    output logic                empty,
    input  logic                pop,
    output vdec_pkg::out_word_t out_word
);
    import vdec_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]  st_reg;
    logic [5:0]  it_reg;
    logic        mode_reg, neg_reg;
    logic [1:0]  status_reg;
    logic [CNT_W-1:0] n_reg;
    logic signed [44:0] ab_reg;
    logic [87:0] acc_reg, mcand_reg;
    logic [43:0] mplier_reg, root_reg;
    logic [47:0] rem_reg, dvs_reg, rd_reg;
    logic [61:0] dvd_reg, quot_reg;
    logic [31:0] res_reg;
    logic        out_valid_reg;
    out_word_t   out_reg;

    logic [47:0] rem_sh, trial;
    logic [43:0] root_fin;
    logic [48:0] rs;
    logic signed [45:0] num;
    logic signed [48:0] ab49, den;
    logic [47:0] mag;
    logic [61:0] quot_fin;

    assign empty    = !out_valid_reg;
    assign out_word = out_reg;
    assign job_pop  = (st_reg == ST_IDLE) && job_valid;

    always_comb
    begin
        rem_sh   = {rem_reg[45:0], acc_reg[87:86]};
        trial    = {2'd0, root_reg, 2'b01};
        root_fin = {root_reg[42:0], (rem_sh >= trial)};
        rs       = {rd_reg, dvd_reg[61]};
        ab49     = {{4{ab_reg[44]}}, ab_reg};
        num      = $signed({2'd0, root_fin}) - $signed({ab_reg[44], ab_reg});
        den      = $signed({5'd0, root_fin}) + (ab49 <<< 3) + (ab49 <<< 1);
        mag      = den[48] ? 48'(-den) : den[47:0];
        quot_fin = {quot_reg[60:0], (rs >= {1'b0, dvs_reg})};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        if (job_word.mode == MODE_EUCLID)
                            st_reg <= ST_SQRT;
                        else if (job_word.sum_aa == '0 || job_word.sum_bb == '0)
                            st_reg <= ST_DONE;
                        else
                            st_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (it_reg == 6'd43)
                        st_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (it_reg == 6'd43)
                    begin
                        if (mode_reg == MODE_COSINE && den == '0)
                            st_reg <= ST_DONE;
                        else
                            st_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (it_reg == 6'd61)
                        st_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        st_reg        <= ST_IDLE;
                    end
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                it_reg     <= '0;
                mode_reg   <= job_word.mode;
                n_reg      <= job_word.count;
                ab_reg     <= job_word.sum_ab;
                rem_reg    <= '0;
                root_reg   <= '0;
                mcand_reg  <= {44'd0, job_word.sum_aa};
                mplier_reg <= job_word.sum_bb;
                if (job_word.mode == MODE_EUCLID)
                    acc_reg <= {34'd0, job_word.sum_sq_diff, 8'd0};
                else
                    acc_reg <= '0;
                res_reg <= 32'h0001_0000;
                if (job_word.overflow)
                    status_reg <= STATUS_LEN_OVF;
                else if (job_word.mode == MODE_COSINE &&
                         (job_word.sum_aa == '0 || job_word.sum_bb == '0))
                    status_reg <= STATUS_ZERO_NRM;
                else
                    status_reg <= STATUS_OK;
            end
            ST_MUL:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[86:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[43:1]};
                it_reg     <= (it_reg == 6'd43) ? 6'd0 : it_reg + 1'b1;
            end
            ST_SQRT:
            begin
                if (it_reg != 6'd43)
                begin
                    acc_reg <= {acc_reg[85:0], 2'b00};
                    if (rem_sh >= trial)
                    begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[42:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[42:0], 1'b0};
                    end
                    it_reg <= it_reg + 1'b1;
                end
                else
                begin
                    // last root bit folded in here, operands set up from it
                    it_reg   <= '0;
                    rd_reg   <= '0;
                    quot_reg <= '0;
                    res_reg  <= 32'h7FFF_FFFF;
                    if (mode_reg == MODE_EUCLID)
                    begin
                        dvd_reg <= {18'd0, root_fin};
                        dvs_reg <= {35'd0, n_reg};
                        neg_reg <= 1'b0;
                    end
                    else
                    begin
                        dvd_reg <= {num, 16'd0};
                        dvs_reg <= mag;
                        neg_reg <= den[48];
                    end
                end
            end
            ST_DIV:
            begin
                dvd_reg  <= {dvd_reg[60:0], 1'b0};
                quot_reg <= quot_fin;
                if (rs >= {1'b0, dvs_reg})
                    rd_reg <= 48'(rs - {1'b0, dvs_reg});
                else
                    rd_reg <= rs[47:0];
                it_reg <= it_reg + 1'b1;
                if (it_reg == 6'd61)
                begin
                    if (mode_reg == MODE_EUCLID)
                        res_reg <= quot_fin[31:0];
                    else if (!neg_reg)
                        res_reg <= (quot_fin > 62'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                              : quot_fin[31:0];
                    else
                        res_reg <= (quot_fin > 62'h8000_0000) ? 32'h8000_0000
                                                              : 32'(-quot_fin[31:0]);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    out_reg.dist_value <= res_reg;
                    out_reg.status     <= status_reg;
                end
            end
            default:
            begin
                it_reg <= '0;
            end
        endcase
    end

endmodule
